// File: design/dcctbd_pkg.sv
package dcctbd_pkg;

  localparam int FILTER_TAPS = 3;
  localparam int HIST_W      = FILTER_TAPS;
  localparam int CNT_W       = $clog2(FILTER_TAPS + 1);
  localparam logic [CNT_W-1:0] MAJORITY = CNT_W'((FILTER_TAPS + 1) / 2);

  localparam int TS_W      = 16;
  localparam int BYTE_W    = 8;
  localparam int BIT_CNT_W = $clog2(BYTE_W);

  localparam logic [TS_W-1:0] THRESH_RESET = 16'd1580;

  typedef struct packed {
    logic            level;
    logic [TS_W-1:0] timestamp;
  } sample_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] value;
  } result_t;

endpackage

// File: design/dcctbd_in_stage.sv
module dcctbd_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dcctbd_pkg::sample_t in_sample,
  input  logic                advance,
  output logic                s1_valid,
  output dcctbd_pkg::sample_t s1_sample
);

  logic                valid_r;
  logic                valid_nxt;
  dcctbd_pkg::sample_t sample_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;
  assign s1_valid  = valid_r;
  assign s1_sample = sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r <= in_sample;
    end
  end

endmodule

// File: design/dcctbd_decode.sv
module dcctbd_decode (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 fire,
  input  dcctbd_pkg::sample_t                  sample,
  input  logic [dcctbd_pkg::TS_W-1:0]          threshold,
  output dcctbd_pkg::result_t                  result
);

  logic [dcctbd_pkg::HIST_W-1:0]    hist_r;
  logic [dcctbd_pkg::HIST_W-1:0]    hist_nxt;
  logic [dcctbd_pkg::HIST_W:0]      hist_ext;
  logic [dcctbd_pkg::CNT_W-1:0]     high_cnt;
  logic                             filtered;
  logic                             level_r;
  logic [dcctbd_pkg::TS_W-1:0]      edge_time_r;
  logic [dcctbd_pkg::TS_W-1:0]      spacing;
  logic                             half;
  logic                             edge_det;
  logic                             pend_valid_r;
  logic                             pend_valid_nxt;
  logic                             pend_value_r;
  logic                             bit_ok;
  logic [dcctbd_pkg::BYTE_W-1:0]    byte_shift_r;
  logic [dcctbd_pkg::BYTE_W-1:0]    byte_shift_nxt;
  logic [dcctbd_pkg::BYTE_W-1:0]    byte_full;
  logic [dcctbd_pkg::BIT_CNT_W-1:0] bit_count_r;
  logic [dcctbd_pkg::BIT_CNT_W-1:0] bit_count_nxt;
  logic                             byte_done;

  always_comb begin
    hist_ext = {hist_r, sample.level};
    hist_nxt = hist_ext[dcctbd_pkg::HIST_W-1:0];
    high_cnt = '0;
    for (int i = 0; i < dcctbd_pkg::HIST_W; i++) begin
      high_cnt = high_cnt + {{(dcctbd_pkg::CNT_W-1){1'b0}}, hist_nxt[i]};
    end
  end

  assign filtered = (high_cnt >= dcctbd_pkg::MAJORITY);
  assign edge_det = (filtered != level_r);
  assign spacing  = sample.timestamp - edge_time_r;
  assign half     = (spacing < threshold);

  assign pend_valid_nxt = edge_det ? !pend_valid_r : pend_valid_r;
  assign bit_ok         = edge_det && pend_valid_r && (half == pend_value_r);
  assign byte_done      = bit_ok && (bit_count_r == {dcctbd_pkg::BIT_CNT_W{1'b1}});

  always_comb begin
    byte_full              = byte_shift_r;
    byte_full[bit_count_r] = half;
  end

  always_comb begin
    byte_shift_nxt = byte_shift_r;
    bit_count_nxt  = bit_count_r;
    if (bit_ok) begin
      byte_shift_nxt = byte_done ? '0 : byte_full;
      bit_count_nxt  = bit_count_r + 1'b1;
    end
  end

  assign result.valid = fire && byte_done;
  assign result.value = byte_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r       <= '0;
      level_r      <= 1'b0;
      edge_time_r  <= '0;
      pend_valid_r <= 1'b0;
      pend_value_r <= 1'b0;
      byte_shift_r <= '0;
      bit_count_r  <= '0;
    end else if (fire) begin
      hist_r       <= hist_nxt;
      level_r      <= filtered;
      pend_valid_r <= pend_valid_nxt;
      byte_shift_r <= byte_shift_nxt;
      bit_count_r  <= bit_count_nxt;
      if (edge_det) begin
        edge_time_r  <= sample.timestamp;
        pend_value_r <= half;
      end
    end
  end

`ifndef SYNTHESIS
  a_result_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    result.valid |-> fire && bit_ok)
    else $error("byte emitted without a processed word");

  a_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
    result.valid |=> (bit_count_r == '0) && (byte_shift_r == '0))
    else $error("byte assembly not cleared after emit");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(bit_count_r) && $stable(byte_shift_r) && $stable(pend_valid_r))
    else $error("decoder state moved without a word");
`endif

endmodule

// File: design/dcctbd_out_stage.sv
module dcctbd_out_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dcctbd_pkg::result_t               result,
  output logic                              out_free,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dcctbd_pkg::BYTE_W-1:0]     out_byte_value
);

  logic                          valid_r;
  logic                          valid_nxt;
  logic [dcctbd_pkg::BYTE_W-1:0] byte_r;

  assign out_free       = !valid_r || out_ready;
  assign valid_nxt      = out_free ? result.valid : valid_r;
  assign out_valid      = valid_r;
  assign out_byte_value = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && result.valid) begin
      byte_r <= result.value;
    end
  end

endmodule

// File: design/dcc_track_bit_decoder_core.sv
// Path: a word accepted into the input register is decoded and, if it completes a byte, loads the output register.
// Throughput: one word per cycle; input register, decode logic and output register
// all advance together, stalling only while a finished byte waits on out_ready.
// Reset: synchronous on rst_n low; clears filter, edge, pair and byte state,
// empties both registers and sets the threshold to 1580.
module dcc_track_bit_decoder_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_pin_level,
  input  logic [dcctbd_pkg::TS_W-1:0]       in_timestamp,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dcctbd_pkg::BYTE_W-1:0]     out_byte_value,
  input  logic                              cfg_wr_en,
  input  logic [dcctbd_pkg::TS_W-1:0]       cfg_wr_data
);

  logic [dcctbd_pkg::TS_W-1:0] threshold_r;
  dcctbd_pkg::sample_t         in_sample;
  dcctbd_pkg::sample_t         s1_sample;
  dcctbd_pkg::result_t         result;
  logic                        s1_valid;
  logic                        out_free;
  logic                        fire;

  assign in_sample.level     = in_pin_level;
  assign in_sample.timestamp = in_timestamp;
  assign fire                = s1_valid && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= dcctbd_pkg::THRESH_RESET;
    end else if (cfg_wr_en) begin
      threshold_r <= cfg_wr_data;
    end
  end

  dcctbd_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .advance   (fire),
    .s1_valid  (s1_valid),
    .s1_sample (s1_sample)
  );

  dcctbd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .sample    (s1_sample),
    .threshold (threshold_r),
    .result    (result)
  );

  dcctbd_out_stage u_out_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .result         (result),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte_value (out_byte_value)
  );

endmodule
